FILE: rtl/kvt_pkg.sv
// shared types and codes for the key value table
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COUNT_W = 6;

  localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd2;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_DEL = 2'd1,
    OP_GET = 2'd2,
    OP_BAD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_CMD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_SCAN  = 2'd2,
    BK_EXEC  = 2'd3
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [WORD_W-1:0]  read_value;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/key_value_table.sv
// key value table top level
// a command passes the command queue, a scan of every entry and the result queue; a bad command skips the scan
// one command at a time: the next is taken only after the scan of every entry
//   through the single read port of the table memories and the result transfer
// reset: all control state cleared at once; a clearing pass then
//   marks every entry free, and full stays high until it is done
`timescale 1ns / 1ps
`default_nettype none

module key_value_table #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [kvt_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [kvt_pkg::WORD_W-1:0]   key_i,
  input  wire logic [kvt_pkg::WORD_W-1:0]   value_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [1:0]                        status_o,
  output logic [kvt_pkg::WORD_W-1:0]        read_value_o,
  output logic [kvt_pkg::COUNT_W-1:0]       entry_count_o
);

  logic          ready;
  logic          cmd_valid, cmd_pop;
  kvt_pkg::cmd_t cmd;
  kvt_pkg::res_t res;

  kvt_front #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_i     (ready),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  kvt_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (ready),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign status_o      = res.status;
  assign read_value_o  = res.read_value;
  assign entry_count_o = res.entry_count;

endmodule

`default_nettype wire

FILE: rtl/kvt_fifo.sv
// small first-in first-out queue
`timescale 1ns / 1ps
`default_nettype none

module kvt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kvt_front.sv
// command intake: decode, trim to configured widths and queue
`timescale 1ns / 1ps
`default_nettype none

module kvt_front #(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          ready_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [kvt_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [kvt_pkg::WORD_W-1:0]    key_i,
  input  wire logic [kvt_pkg::WORD_W-1:0]    value_i,
  output logic                               cmd_valid_o,
  output kvt_pkg::cmd_t                      cmd_o,
  input  wire logic                          cmd_pop_i
);

  localparam int unsigned CMD_BITS = $bits(kvt_pkg::cmd_t);

  kvt_pkg::cmd_t       cmd_in;
  logic [CMD_BITS-1:0] q_out;
  logic                q_full, q_empty;

  always_comb begin
    case (cmd_i)
      kvt_pkg::CMD_SET: cmd_in.op = kvt_pkg::OP_SET;
      kvt_pkg::CMD_DEL: cmd_in.op = kvt_pkg::OP_DEL;
      kvt_pkg::CMD_GET: cmd_in.op = kvt_pkg::OP_GET;
      default:          cmd_in.op = kvt_pkg::OP_BAD;
    endcase
    cmd_in.key   = kvt_pkg::WORD_W'(key_i[KEY_BITS-1:0]);
    cmd_in.value = kvt_pkg::WORD_W'(value_i[VALUE_BITS-1:0]);
  end

  // held off while the table is being cleared
  assign full = q_full || !ready_i;

  kvt_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && ready_i),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = kvt_pkg::cmd_t'(q_out);

endmodule

`default_nettype wire

FILE: rtl/kvt_back.sv
// table engine: entry scan, update and result queue
`timescale 1ns / 1ps
`default_nettype none

module kvt_back #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  output logic                            ready_o,
  input  wire logic                       cmd_valid_i,
  input  wire kvt_pkg::cmd_t              cmd_i,
  output logic                            cmd_pop_o,
  output logic                            empty,
  input  wire logic                       pop,
  output kvt_pkg::res_t                   res_o
);

  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned RES_BITS = $bits(kvt_pkg::res_t);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  // table storage
  logic                  vld_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];

  kvt_pkg::back_state_e  state_q, state_d;
  kvt_pkg::cmd_t         cur_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  issue_done_q;
  logic                  rd_en, rd_en_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  vld_rd_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic                  hit_q, free_q;
  logic [IDX_W-1:0]      hit_slot_q, free_slot_q;
  logic [VALUE_BITS-1:0] hit_val_q;
  logic [CNT_W-1:0]      count_q, count_d;

  logic                  vld_we, vld_wdata;
  logic [IDX_W-1:0]      vld_waddr;
  logic                  key_we, val_we;
  logic [IDX_W-1:0]      kv_waddr;
  logic                  res_push, res_full;
  kvt_pkg::res_t         res_d;
  logic [RES_BITS-1:0]   res_q_out;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kvt_pkg::BK_CLEAR: begin
        if (idx_q == LAST) state_d = kvt_pkg::BK_IDLE;
      end
      kvt_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == kvt_pkg::OP_BAD) ? kvt_pkg::BK_EXEC : kvt_pkg::BK_SCAN;
        end
      end
      kvt_pkg::BK_SCAN: begin
        if (rd_en_q && rd_idx_q == LAST) state_d = kvt_pkg::BK_EXEC;
      end
      kvt_pkg::BK_EXEC: begin
        if (!res_full) state_d = kvt_pkg::BK_IDLE;
      end
      default: state_d = kvt_pkg::BK_CLEAR;
    endcase
  end

  // outputs and command execution
  always_comb begin
    ready_o   = (state_q != kvt_pkg::BK_CLEAR);
    cmd_pop_o = (state_q == kvt_pkg::BK_IDLE) && cmd_valid_i;
    rd_en     = (state_q == kvt_pkg::BK_SCAN) && !issue_done_q;
    res_push  = (state_q == kvt_pkg::BK_EXEC) && !res_full;
    vld_we    = (state_q == kvt_pkg::BK_CLEAR);
    vld_wdata = 1'b0;
    vld_waddr = idx_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    kv_waddr  = hit_slot_q;
    count_d   = count_q;
    res_d.status     = kvt_pkg::ST_OK;
    res_d.read_value = '0;
    case (cur_q.op)
      kvt_pkg::OP_SET: begin
        if (hit_q) begin
          val_we = res_push;
        end else if (free_q) begin
          vld_we    = res_push;
          vld_wdata = 1'b1;
          vld_waddr = free_slot_q;
          key_we    = res_push;
          val_we    = res_push;
          kv_waddr  = free_slot_q;
          count_d   = count_q + 1'b1;
        end else begin
          res_d.status = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::OP_DEL: begin
        if (hit_q) begin
          vld_we    = res_push;
          vld_waddr = hit_slot_q;
          if (count_q != '0) count_d = count_q - 1'b1;
        end
      end
      kvt_pkg::OP_GET: begin
        if (hit_q) begin
          res_d.read_value = kvt_pkg::WORD_W'(hit_val_q);
        end else begin
          res_d.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      default: res_d.status = kvt_pkg::ST_BAD_CMD;
    endcase
    res_d.entry_count = kvt_pkg::COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kvt_pkg::BK_CLEAR;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      rd_en_q      <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      count_q      <= '0;
    end else begin
      state_q <= state_d;
      rd_en_q <= rd_en;
      if (state_q == kvt_pkg::BK_CLEAR) begin
        idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
      end
      if (cmd_pop_o) begin
        idx_q        <= '0;
        issue_done_q <= 1'b0;
        hit_q        <= 1'b0;
        free_q       <= 1'b0;
      end
      if (rd_en) begin
        if (idx_q == LAST) begin
          issue_done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (rd_en_q) begin
        if (vld_rd_q) begin
          if (!hit_q && key_rd_q == cur_q.key[KEY_BITS-1:0]) hit_q <= 1'b1;
        end else if (!free_q) begin
          free_q <= 1'b1;
        end
      end
      if (res_push) count_q <= count_d;
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    rd_idx_q <= idx_q;
    if (rd_en_q) begin
      if (vld_rd_q) begin
        if (!hit_q && key_rd_q == cur_q.key[KEY_BITS-1:0]) begin
          hit_slot_q <= rd_idx_q;
          hit_val_q  <= val_rd_q;
        end
      end else if (!free_q) begin
        free_slot_q <= rd_idx_q;
      end
    end
  end

  // table memories
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      vld_rd_q <= vld_mem[idx_q];
      key_rd_q <= key_mem[idx_q];
      val_rd_q <= val_mem[idx_q];
    end
    if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
    if (key_we) key_mem[kv_waddr]  <= cur_q.key[KEY_BITS-1:0];
    if (val_we) val_mem[kv_waddr]  <= cur_q.value[VALUE_BITS-1:0];
  end

  kvt_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_q_out),
    .empty_o (empty)
  );

  assign res_o = kvt_pkg::res_t'(res_q_out);

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kvt_pkg::BK_SCAN |-> !(vld_we || key_we || val_we))
    else $error("table written during scan");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count above table size");

  a_count_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_push |=> count_q == $past(count_q))
    else $error("entry count changed without result transfer");

  a_first_hit_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvt_pkg::BK_SCAN && hit_q && !cmd_pop_o) |=> $stable(hit_slot_q))
    else $error("matching slot changed after first hit");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the key value table with a shadow table predictor
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ENTRIES     = 32;
  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned LATENCY     = ENTRIES + 4;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned RANDOM_CMDS = 1700;
  localparam int unsigned POOL_SIZE   = 48;

  localparam logic [kvt_pkg::WORD_W-1:0] ONES       = '1;
  localparam logic [kvt_pkg::WORD_W-1:0] ALT_A      = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [kvt_pkg::WORD_W-1:0] ALT_5      = 64'h5555_5555_5555_5555;
  localparam logic [kvt_pkg::WORD_W-1:0] KEY_MASK   = ONES >> (kvt_pkg::WORD_W - KEY_BITS);
  localparam logic [kvt_pkg::WORD_W-1:0] VALUE_MASK = ONES >> (kvt_pkg::WORD_W - VALUE_BITS);

  typedef enum int unsigned {
    POP_ALWAYS,
    POP_HALF,
    POP_QUARTER,
    POP_RARE
  } pop_mode_e;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_EMPTY,
    MIX_EVEN
  } cmd_mix_e;

  class table_shadow;
    bit                         used[ENTRIES];
    logic [kvt_pkg::WORD_W-1:0] keys[ENTRIES];
    logic [kvt_pkg::WORD_W-1:0] values[ENTRIES];
    int unsigned                occupied;
    kvt_pkg::res_t              expected_responses[$];
    int unsigned                errors;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_command(logic [kvt_pkg::CMD_W-1:0] cmd,
                               logic [kvt_pkg::WORD_W-1:0] key_in,
                               logic [kvt_pkg::WORD_W-1:0] value_in);
      logic [kvt_pkg::WORD_W-1:0] k;
      logic [kvt_pkg::WORD_W-1:0] v;
      kvt_pkg::res_t              r;
      bit                         hit;
      bit                         have_free;
      int unsigned                hit_slot;
      int unsigned                free_slot;
      k = key_in & KEY_MASK;
      v = value_in & VALUE_MASK;
      r.status = kvt_pkg::ST_OK;
      r.read_value = '0;
      hit = 1'b0;
      have_free = 1'b0;
      hit_slot = 0;
      free_slot = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (used[i]) begin
          if (!hit && keys[i] == k) begin
            hit = 1'b1;
            hit_slot = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      case (kvt_pkg::op_e'(cmd))
        kvt_pkg::OP_SET: begin
          if (hit) begin
            values[hit_slot] = v;
          end else if (have_free) begin
            used[free_slot] = 1'b1;
            keys[free_slot] = k;
            values[free_slot] = v;
            occupied++;
          end else begin
            r.status = kvt_pkg::ST_FULL;
          end
        end
        kvt_pkg::OP_DEL: begin
          if (hit) begin
            used[hit_slot] = 1'b0;
            keys[hit_slot] = '0;
            values[hit_slot] = '0;
            if (occupied > 0) occupied--;
          end
        end
        kvt_pkg::OP_GET: begin
          if (hit) r.read_value = values[hit_slot];
          else r.status = kvt_pkg::ST_NOT_FOUND;
        end
        default: begin
          r.status = kvt_pkg::ST_BAD_CMD;
        end
      endcase
      r.entry_count = kvt_pkg::COUNT_W'(occupied);
      expected_responses.push_back(r);
    endfunction

    task check_response(logic [1:0] status, logic [kvt_pkg::WORD_W-1:0] rd_value,
                        logic [kvt_pkg::COUNT_W-1:0] count);
      kvt_pkg::res_t e;
      if (expected_responses.size() == 0) begin
        report($sformatf("response with none pending, status %0d", status));
        return;
      end
      e = expected_responses.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (rd_value !== e.read_value)
        report($sformatf("read_value %h, expected %h", rd_value, e.read_value));
      if (count !== e.entry_count)
        report($sformatf("entry_count %0d, expected %0d", count, e.entry_count));
    endtask
  endclass

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        push    = 1'b0;
  logic                        pop     = 1'b0;
  logic [kvt_pkg::CMD_W-1:0]   cmd_i   = '0;
  logic [kvt_pkg::WORD_W-1:0]  key_i   = '0;
  logic [kvt_pkg::WORD_W-1:0]  value_i = '0;
  logic                        full;
  logic                        empty;
  logic [1:0]                  status_o;
  logic [kvt_pkg::WORD_W-1:0]  read_value_o;
  logic [kvt_pkg::COUNT_W-1:0] entry_count_o;

  table_shadow shadow = new;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  pop_mode_e   pop_mode = POP_ALWAYS;
  int unsigned mode_left = 0;
  logic [kvt_pkg::WORD_W-1:0] key_pool[POOL_SIZE];

  key_value_table #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) shadow.note_command(cmd_i, key_i, value_i);
      if (pop && !empty) shadow.check_response(status_o, read_value_o, entry_count_o);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** key_value_table: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side stalls on its own changing pattern
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      pop_mode <= pop_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (pop_mode)
      POP_ALWAYS:  pop <= 1'b1;
      POP_HALF:    pop <= 1'($urandom_range(0, 1));
      POP_QUARTER: pop <= ($urandom_range(0, 3) == 0);
      default:     pop <= ($urandom_range(0, 15) == 0);
    endcase
  end

  function automatic logic [kvt_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_command(kvt_pkg::op_e op, logic [kvt_pkg::WORD_W-1:0] key_w,
                              logic [kvt_pkg::WORD_W-1:0] value_w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    push <= 1'b1;
    cmd_i <= op;
    key_i <= key_w;
    value_i <= value_w;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (shadow.expected_responses.size() != 0);
    @(posedge clk_i);
  endtask

  initial begin
    cmd_mix_e                   mix;
    kvt_pkg::op_e               op;
    int unsigned                pick;
    int unsigned                slot;
    int unsigned                sent;
    logic [kvt_pkg::WORD_W-1:0] k;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // misses on an empty table, extremes, overwrite, bad command, slot reuse
    send_command(kvt_pkg::OP_GET, '0, '0);
    send_command(kvt_pkg::OP_DEL, '0, ONES);
    send_command(kvt_pkg::OP_SET, '0, ONES);
    send_command(kvt_pkg::OP_SET, ONES, '0);
    send_command(kvt_pkg::OP_GET, '0, '0);
    send_command(kvt_pkg::OP_GET, ONES, ONES);
    send_command(kvt_pkg::OP_SET, '0, ALT_5);
    send_command(kvt_pkg::OP_GET, '0, '0);
    send_command(kvt_pkg::OP_BAD, ONES, ONES);
    send_command(kvt_pkg::OP_DEL, '0, '0);
    send_command(kvt_pkg::OP_GET, '0, '0);
    send_command(kvt_pkg::OP_DEL, '0, '0);
    send_command(kvt_pkg::OP_SET, ALT_A, ALT_5);
    send_command(kvt_pkg::OP_SET, ALT_5, ALT_A);
    send_command(kvt_pkg::OP_GET, ALT_A, '0);
    send_command(kvt_pkg::OP_GET, ALT_5, '0);
    send_command(kvt_pkg::OP_DEL, ONES, '0);
    send_command(kvt_pkg::OP_SET, '0, '0);
    send_command(kvt_pkg::OP_SET, 64'd1, ONES);
    send_command(kvt_pkg::OP_GET, 64'd1, '0);
    send_command(kvt_pkg::OP_BAD, '0, '0);
    send_command(kvt_pkg::OP_DEL, ALT_A, '0);
    send_command(kvt_pkg::OP_GET, ALT_A, '0);
    wait_drained();

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = ONES;

    // phases lean toward filling, emptying or an even mix so the count sweeps 0..full
    while (sent < RANDOM_CMDS) begin
      mix = cmd_mix_e'($urandom_range(0, 2));
      repeat ($urandom_range(80, 240)) begin
        pick = $urandom_range(0, 99);
        case (mix)
          MIX_FILL: begin
            op = (pick < 70) ? kvt_pkg::OP_SET : (pick < 80) ? kvt_pkg::OP_DEL :
                 (pick < 96) ? kvt_pkg::OP_GET : kvt_pkg::OP_BAD;
          end
          MIX_EMPTY: begin
            op = (pick < 15) ? kvt_pkg::OP_SET : (pick < 70) ? kvt_pkg::OP_DEL :
                 (pick < 95) ? kvt_pkg::OP_GET : kvt_pkg::OP_BAD;
          end
          default: begin
            op = (pick < 35) ? kvt_pkg::OP_SET : (pick < 65) ? kvt_pkg::OP_DEL :
                 (pick < 95) ? kvt_pkg::OP_GET : kvt_pkg::OP_BAD;
          end
        endcase
        if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
        else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        // aim delete and get at stored keys often so hits dominate
        if (op != kvt_pkg::OP_SET && $urandom_range(0, 1) == 0) begin
          slot = $urandom_range(0, ENTRIES - 1);
          if (shadow.used[slot]) k = shadow.keys[slot];
        end
        send_command(op, k, random_word());
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.expected_responses.size() == 0) begin
      $display("** key_value_table: PASSED **");
    end else begin
      $display("** key_value_table: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/kvt_pkg.sv
rtl/kvt_fifo.sv
rtl/kvt_front.sv
rtl/kvt_back.sv
rtl/key_value_table.sv
sim/testbench.sv
